@@ rtl/tls_client_hello_sni_alpn_parser_assert.svh @@
`ifndef TLS_CLIENT_HELLO_SNI_ALPN_PARSER_ASSERT_SVH
`define TLS_CLIENT_HELLO_SNI_ALPN_PARSER_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define TLSCP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlscp same-cycle check failed");

// property that must hold in the cycle after its trigger
`define TLSCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlscp next-cycle check failed");

`endif

@@ rtl/tlscp_pkg.sv @@
`default_nettype none

package tlscp_pkg;

   localparam int SNI_BYTES = 32;
   localparam int ALPN_BYTES = 32;
   localparam int SNI_DEPTH = SNI_BYTES - 1;
   localparam int ALPN_DEPTH = ALPN_BYTES - 1;
   localparam int HDR_BYTES = 5;
   localparam int RSP_DATA_BITS = 56;

   localparam logic [7:0] CONTENT_HANDSHAKE = 8'h16;
   localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
   localparam logic [7:0] MAJOR_VERSION = 8'h03;
   localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
   localparam logic [15:0] EXT_ALPN = 16'h0010;
   localparam logic [15:0] RANDOM_BYTES = 16'd32;
   localparam logic [7:0] ALPN_SEPARATOR = 8'h2c;
   localparam logic [16:0] SEEN_MAX = 17'h1ffff;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_MATCH  = 2'd1,
      ST_NEED_MORE = 2'd2,
      ST_MALFORMED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_SNI    = 2'd1,
      KIND_ALPN   = 2'd2
   } kind_type;

   typedef enum logic [21:0] {
      PH_HDR     = 22'b1 << 0,
      PH_IGNORE  = 22'b1 << 1,
      PH_DONE    = 22'b1 << 2,
      PH_CVER    = 22'b1 << 3,
      PH_RANDOM  = 22'b1 << 4,
      PH_SIDLEN  = 22'b1 << 5,
      PH_SID     = 22'b1 << 6,
      PH_CSLEN   = 22'b1 << 7,
      PH_CS      = 22'b1 << 8,
      PH_CMLEN   = 22'b1 << 9,
      PH_CM      = 22'b1 << 10,
      PH_EXTLEN  = 22'b1 << 11,
      PH_EXTTYPE = 22'b1 << 12,
      PH_EXTSIZE = 22'b1 << 13,
      PH_EXTSKIP = 22'b1 << 14,
      PH_SLIST   = 22'b1 << 15,
      PH_STYPE   = 22'b1 << 16,
      PH_SNLEN   = 22'b1 << 17,
      PH_SNAME   = 22'b1 << 18,
      PH_ALIST   = 22'b1 << 19,
      PH_APLEN   = 22'b1 << 20,
      PH_APROTO  = 22'b1 << 21
   } phase_type;

   // phases inside one extension body
   localparam logic [21:0] EXT_MASK = 22'(PH_EXTSKIP) | 22'(PH_SLIST) | 22'(PH_STYPE) |
      22'(PH_SNLEN) | 22'(PH_SNAME) | 22'(PH_ALIST) | 22'(PH_APLEN) | 22'(PH_APROTO);
   // phases inside the extension block
   localparam logic [21:0] BLOCK_MASK = EXT_MASK | 22'(PH_EXTTYPE) | 22'(PH_EXTSIZE);

   typedef struct packed {
      phase_type   phase;
      logic [23:0] body_rem;
      logic [15:0] nr_block;
      logic [15:0] nr_ext;
      logic [15:0] nr_left;
      logic [15:0] nr_type;
      logic [15:0] field_acc;
      logic [15:0] hello_ver;
      logic        fault;
      logic        cap_on;
      logic [4:0]  cap_left;
      logic [4:0]  alpn_count;
      logic        comma_wr;
   } walk_type;

   localparam walk_type WALK_RESET = '{phase: PH_HDR, default: '0};

   typedef struct packed {
      status_type  status;
      logic [15:0] record_ver;
      logic [15:0] client_ver;
      logic [4:0]  sni_len;
      logic [4:0]  alpn_len;
   } summary_type;

   typedef logic [SNI_DEPTH-1:0][7:0] sni_view_type;
   typedef logic [ALPN_DEPTH-1:0][7:0] alpn_view_type;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic [4:0]  alpn_length;
      logic [4:0]  sni_length;
      logic [15:0] client_version;
      logic [15:0] record_version;
      status_type  status;
   } rsp_item_type;

   function automatic logic is_body(phase_type p);
      return (p != PH_HDR) && (p != PH_IGNORE) && (p != PH_DONE);
   endfunction

   function automatic logic in_block(phase_type p);
      return |(22'(p) & BLOCK_MASK);
   endfunction

   function automatic logic in_ext(phase_type p);
      return |(22'(p) & EXT_MASK);
   endfunction

   function automatic walk_type walk_fail(walk_type w);
      walk_type r;
      r = w;
      r.fault = 1'b1;
      r.phase = PH_IGNORE;
      return r;
   endfunction

   function automatic walk_type walk_begin(walk_type w, phase_type ph, logic [15:0] n,
                                           logic [23:0] bound);
      walk_type r;
      r = w;
      if ({8'd0, n} > bound) begin
         r = walk_fail(w);
      end else begin
         r.phase = ph;
         r.nr_left = n;
         r.field_acc = '0;
      end
      return r;
   endfunction

   function automatic walk_type walk_ext_after(walk_type w);
      walk_type r;
      r = w;
      if (w.nr_block == 16'd0) r.phase = PH_DONE;
      else r = walk_begin(w, PH_EXTTYPE, 16'd2, {8'd0, w.nr_block});
      return r;
   endfunction

   function automatic walk_type walk_list_next(walk_type w, phase_type ph);
      walk_type r;
      r = w;
      if (w.nr_ext == 16'd0) r = walk_ext_after(w);
      else r = walk_begin(w, ph, 16'd1, {8'd0, w.nr_ext});
      return r;
   endfunction

   // one field of the hello body has been read completely
   function automatic walk_type walk_finish(walk_type w, logic [4:0] sni_count);
      walk_type r;
      logic [15:0] v;
      logic [23:0] ext;
      r = w;
      v = w.field_acc;
      ext = {8'd0, w.nr_ext};
      r.cap_on = 1'b0;
      unique case (w.phase)
         PH_CVER: begin
            r.hello_ver = v;
            r = walk_begin(r, PH_RANDOM, RANDOM_BYTES, r.body_rem);
         end
         PH_RANDOM: r = walk_begin(r, PH_SIDLEN, 16'd1, r.body_rem);
         PH_SIDLEN: r = walk_begin(r, PH_SID, v, r.body_rem);
         PH_SID: r = walk_begin(r, PH_CSLEN, 16'd2, r.body_rem);
         PH_CSLEN: begin
            if (v == 16'd0 || v[0]) r = walk_fail(r);
            else r = walk_begin(r, PH_CS, v, r.body_rem);
         end
         PH_CS: r = walk_begin(r, PH_CMLEN, 16'd1, r.body_rem);
         PH_CMLEN: begin
            if (v == 16'd0) r = walk_fail(r);
            else r = walk_begin(r, PH_CM, v, r.body_rem);
         end
         PH_CM: begin
            if (r.body_rem == 24'd0) r.phase = PH_DONE;
            else r = walk_begin(r, PH_EXTLEN, 16'd2, r.body_rem);
         end
         PH_EXTLEN: begin
            if ({8'd0, v} > r.body_rem) begin
               r = walk_fail(r);
            end else begin
               r.nr_block = v;
               r = walk_ext_after(r);
            end
         end
         PH_EXTTYPE: begin
            r.nr_type = v;
            r = walk_begin(r, PH_EXTSIZE, 16'd2, {8'd0, r.nr_block});
         end
         PH_EXTSIZE: begin
            if (v > r.nr_block) begin
               r = walk_fail(r);
            end else begin
               r.nr_ext = v;
               if (r.nr_type == EXT_SERVER_NAME) r = walk_begin(r, PH_SLIST, 16'd2, {8'd0, v});
               else if (r.nr_type == EXT_ALPN) r = walk_begin(r, PH_ALIST, 16'd2, {8'd0, v});
               else r = walk_begin(r, PH_EXTSKIP, v, {8'd0, v});
            end
         end
         PH_EXTSKIP: r = walk_ext_after(r);
         PH_SLIST: begin
            if ({8'd0, v} != ext) r = walk_fail(r);
            else r = walk_list_next(r, PH_STYPE);
         end
         PH_STYPE: begin
            r.nr_type = v;
            r = walk_begin(r, PH_SNLEN, 16'd2, ext);
         end
         PH_SNLEN: begin
            if (v == 16'd0 || {8'd0, v} > ext) begin
               r = walk_fail(r);
            end else begin
               r = walk_begin(r, PH_SNAME, v, ext);
               // only the first non-empty host name is kept
               r.cap_on = (w.nr_type == 16'd0) && (sni_count == 5'd0);
               r.cap_left = 5'(SNI_BYTES - 1);
            end
         end
         PH_SNAME: r = walk_list_next(r, PH_STYPE);
         PH_ALIST: begin
            if ({8'd0, v} != ext) r = walk_fail(r);
            else r = walk_list_next(r, PH_APLEN);
         end
         PH_APLEN: begin
            if (v == 16'd0 || {8'd0, v} > ext) begin
               r = walk_fail(r);
            end else if (w.alpn_count != 5'd0 &&
                         ({1'b0, w.alpn_count} + 6'd1 >= 6'(ALPN_BYTES))) begin
               r = walk_fail(r);
            end else begin
               if (w.alpn_count != 5'd0) begin
                  r.comma_wr = 1'b1;
                  r.alpn_count = w.alpn_count + 5'd1;
               end
               r = walk_begin(r, PH_APROTO, v, ext);
               r.cap_on = 1'b1;
               r.cap_left = 5'(ALPN_BYTES - 1) - r.alpn_count;
            end
         end
         PH_APROTO: r = walk_list_next(r, PH_APLEN);
         default: r = walk_fail(r);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/tlscp_parser.sv @@
`default_nettype none

module tlscp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_take,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output logic                    done_load,
   output tlscp_pkg::summary_type  done_summary,
   output tlscp_pkg::sni_view_type sni_view,
   output tlscp_pkg::alpn_view_type alpn_view
);
   import tlscp_pkg::*;

   walk_type    walk_ff, walk_in;
   logic [16:0] seen_ff, seen_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  hs_type_ff, hs_type_in;
   logic [15:0] rec_ver_ff, rec_ver_in;
   logic [15:0] rec_len_ff, rec_len_in;
   logic        started_ff, started_in;
   logic [4:0]  sni_count_ff, sni_count_in;
   logic [7:0]  sni_text_ff [SNI_DEPTH];
   logic [7:0]  alpn_text_ff [ALPN_DEPTH];
   logic        sni_wr;
   logic        alpn_wr;
   logic [4:0]  alpn_wr_idx;
   logic [7:0]  alpn_wr_data;
   logic [16:0] need_len;
   phase_type   ph;

   always_comb begin
      walk_in = walk_ff;
      seen_in = (seen_ff < SEEN_MAX) ? seen_ff + 17'd1 : seen_ff;
      first_in = first_ff;
      hs_type_in = hs_type_ff;
      rec_ver_in = rec_ver_ff;
      rec_len_in = rec_len_ff;
      started_in = started_ff;
      sni_count_in = sni_count_ff;
      sni_wr = 1'b0;
      alpn_wr = 1'b0;
      alpn_wr_idx = walk_ff.alpn_count;
      alpn_wr_data = in_byte;
      ph = walk_ff.phase;
      if (ph == PH_HDR && seen_ff < 17'd9) begin
         priority if (seen_ff == 17'd0) first_in = in_byte;
         else if (seen_ff <= 17'd2) rec_ver_in = {rec_ver_ff[7:0], in_byte};
         else if (seen_ff <= 17'd4) rec_len_in = {rec_len_ff[7:0], in_byte};
         else if (seen_ff == 17'd5) hs_type_in = in_byte;
         else walk_in.body_rem = {walk_ff.body_rem[15:0], in_byte};
         if (seen_ff == 17'd8) begin
            if (hs_type_ff == HS_CLIENT_HELLO && rec_len_ff >= 16'd4 &&
                walk_in.body_rem <= {8'd0, rec_len_ff - 16'd4}) begin
               started_in = 1'b1;
               walk_in = walk_begin(walk_in, PH_CVER, 16'd2, walk_in.body_rem);
            end else begin
               walk_in.phase = PH_IGNORE;
            end
         end
      end else if (is_body(ph)) begin
         walk_in.comma_wr = 1'b0;
         if (walk_ff.body_rem != 24'd0) walk_in.body_rem = walk_ff.body_rem - 24'd1;
         if (in_block(ph) && walk_ff.nr_block != 16'd0)
            walk_in.nr_block = walk_ff.nr_block - 16'd1;
         if (in_ext(ph) && walk_ff.nr_ext != 16'd0)
            walk_in.nr_ext = walk_ff.nr_ext - 16'd1;
         if (walk_ff.cap_on && walk_ff.cap_left != 5'd0) begin
            // names are c strings: a zero byte ends the capture
            priority if (in_byte == 8'd0) begin
               walk_in.cap_on = 1'b0;
            end else if (ph == PH_SNAME && {1'b0, sni_count_ff} < 6'(SNI_BYTES)) begin
               sni_wr = 1'b1;
               sni_count_in = sni_count_ff + 5'd1;
               walk_in.cap_left = walk_ff.cap_left - 5'd1;
            end else if (ph == PH_APROTO && {1'b0, walk_ff.alpn_count} < 6'(ALPN_BYTES)) begin
               alpn_wr = 1'b1;
               walk_in.alpn_count = walk_ff.alpn_count + 5'd1;
               walk_in.cap_left = walk_ff.cap_left - 5'd1;
            end else begin
               walk_in.cap_on = walk_ff.cap_on;
            end
         end
         walk_in.field_acc = {walk_ff.field_acc[7:0], in_byte};
         if (walk_ff.nr_left != 16'd0) walk_in.nr_left = walk_ff.nr_left - 16'd1;
         // a zero-length field closes right away, so at most two fields end per word
         if (is_body(walk_in.phase) && walk_in.nr_left == 16'd0)
            walk_in = walk_finish(walk_in, sni_count_in);
         if (is_body(walk_in.phase) && walk_in.nr_left == 16'd0)
            walk_in = walk_finish(walk_in, sni_count_in);
         if (walk_in.comma_wr) begin
            alpn_wr = 1'b1;
            alpn_wr_idx = walk_in.alpn_count - 5'd1;
            alpn_wr_data = ALPN_SEPARATOR;
         end
      end
   end

   // verdict for the buffer, from the state after this word
   always_comb begin
      need_len = 17'(HDR_BYTES) + {1'b0, rec_len_in};
      done_summary = '0;
      priority if (seen_in < 17'(HDR_BYTES)) begin
         done_summary.status = (first_in == CONTENT_HANDSHAKE) ? ST_NEED_MORE : ST_NO_MATCH;
      end else if (first_in != CONTENT_HANDSHAKE || rec_ver_in[15:8] != MAJOR_VERSION) begin
         done_summary.status = ST_NO_MATCH;
         done_summary.record_ver = rec_ver_in;
      end else if (seen_in < need_len) begin
         done_summary.status = ST_NEED_MORE;
         done_summary.record_ver = rec_ver_in;
      end else if (rec_len_in < 16'd4) begin
         done_summary.status = ST_MALFORMED;
         done_summary.record_ver = rec_ver_in;
      end else if (hs_type_in != HS_CLIENT_HELLO) begin
         done_summary.status = ST_NO_MATCH;
      end else if (!started_in) begin
         done_summary.status = ST_NEED_MORE;
      end else if (walk_in.fault || walk_in.phase != PH_DONE) begin
         done_summary.status = ST_MALFORMED;
      end else begin
         done_summary.status = ST_OK;
         done_summary.record_ver = rec_ver_in;
         done_summary.client_ver = walk_in.hello_ver;
         done_summary.sni_len = sni_count_in;
         done_summary.alpn_len = walk_in.alpn_count;
      end
   end

   assign done_load = in_take & in_last;

   // text stores as seen after this word's write
   always_comb begin
      for (int i = 0; i < SNI_DEPTH; i++)
         sni_view[i] = (sni_wr && sni_count_ff == 5'(i)) ? in_byte : sni_text_ff[i];
      for (int i = 0; i < ALPN_DEPTH; i++)
         alpn_view[i] = (alpn_wr && alpn_wr_idx == 5'(i)) ? alpn_wr_data : alpn_text_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset || done_load) begin
         walk_ff <= WALK_RESET;
         seen_ff <= '0;
         first_ff <= '0;
         hs_type_ff <= '0;
         rec_ver_ff <= '0;
         rec_len_ff <= '0;
         started_ff <= 1'b0;
         sni_count_ff <= '0;
      end else if (in_take) begin
         walk_ff <= walk_in;
         seen_ff <= seen_in;
         first_ff <= first_in;
         hs_type_ff <= hs_type_in;
         rec_ver_ff <= rec_ver_in;
         rec_len_ff <= rec_len_in;
         started_ff <= started_in;
         sni_count_ff <= sni_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && sni_wr) sni_text_ff[sni_count_ff] <= in_byte;
      if (in_take && alpn_wr) alpn_text_ff[alpn_wr_idx] <= alpn_wr_data;
   end

endmodule

`default_nettype wire

@@ rtl/tlscp_emitter.sv @@
`default_nettype none

module tlscp_emitter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tlscp_pkg::summary_type   summary,
   input  tlscp_pkg::sni_view_type  sni_view,
   input  tlscp_pkg::alpn_view_type alpn_view,
   input  logic                     out_ready,
   output logic                     out_valid,
   output tlscp_pkg::kind_type      out_kind,
   output tlscp_pkg::rsp_item_type  out_item,
   output logic                     out_last,
   output logic                     free
);
   import tlscp_pkg::*;

   logic          busy_ff;
   logic [5:0]    pos_ff;
   summary_type   sum_ff;
   sni_view_type  sni_ff;
   alpn_view_type alpn_ff;
   logic [5:0]    total;
   logic [4:0]    sni_idx;
   logic [4:0]    alpn_idx;

   assign total = {1'b0, sum_ff.sni_len} + {1'b0, sum_ff.alpn_len};
   assign sni_idx = 5'(pos_ff - 6'd1);
   assign alpn_idx = 5'(pos_ff - 6'd1 - {1'b0, sum_ff.sni_len});
   assign out_valid = busy_ff;
   assign out_last = (pos_ff == total);
   assign free = !busy_ff || (out_ready && out_last);

   // word 0 is the status, then server name bytes, then alpn bytes
   always_comb begin
      out_item = '0;
      if (pos_ff == 6'd0) begin
         out_kind = KIND_STATUS;
         out_item.status = sum_ff.status;
         out_item.record_version = sum_ff.record_ver;
         out_item.client_version = sum_ff.client_ver;
         out_item.sni_length = sum_ff.sni_len;
         out_item.alpn_length = sum_ff.alpn_len;
      end else if (pos_ff <= {1'b0, sum_ff.sni_len}) begin
         out_kind = KIND_SNI;
         out_item.text_byte = sni_ff[sni_idx];
      end else begin
         out_kind = KIND_ALPN;
         out_item.text_byte = alpn_ff[alpn_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         pos_ff <= '0;
      end else if (busy_ff && out_ready) begin
         if (out_last) busy_ff <= 1'b0;
         else pos_ff <= pos_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= summary;
         sni_ff <= sni_view;
         alpn_ff <= alpn_view;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tls_client_hello_sni_alpn_parser.sv @@
// Streaming ClientHello inspector: one buffer arrives as a run of bytes on req, closed by
// tlast. A buffer streams in at one byte per clock, bar a closing byte that is held off;
// the record header, handshake header and body vectors are tracked with small length
// counters as they go by, and the first host name and the comma-joined ALPN list are kept as
// c strings of up to 31 characters each. On the closing byte the verdict and both strings
// are copied into the output stage and the parser is ready for the next buffer in the next
// cycle. The output then sends one status word followed by the name bytes and the ALPN
// bytes, one word per cycle while rsp_tready is high (1 to 63 words, tlast on the final
// one). A closing byte is held off while the previous buffer still has words beyond the
// one now leaving, so a buffer shorter than the previous list waits for the output to drain.
`default_nettype none
`include "tls_client_hello_sni_alpn_parser_assert.svh"

module tls_client_hello_sni_alpn_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // data_byte
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, record_version, client_version, sni_length, alpn_length, text_byte
   output logic [tlscp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]                          rsp_tuser,  // item_kind
   output logic                                rsp_tlast
);
   import tlscp_pkg::*;

   logic          req_take;
   logic          done_load;
   logic          emit_free;
   summary_type   done_summary;
   sni_view_type  sni_view;
   alpn_view_type alpn_view;
   kind_type      rsp_kind;
   rsp_item_type  rsp_item;

   // only the closing byte of a buffer needs room in the output stage
   assign req_tready = emit_free | ~req_tlast;
   assign req_take = req_tvalid & req_tready;

   tlscp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_take      (req_take),
      .in_byte      (req_tdata),
      .in_last      (req_tlast),
      .done_load    (done_load),
      .done_summary (done_summary),
      .sni_view     (sni_view),
      .alpn_view    (alpn_view)
   );

   tlscp_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (done_load),
      .summary   (done_summary),
      .sni_view  (sni_view),
      .alpn_view (alpn_view),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_kind  (rsp_kind),
      .out_item  (rsp_item),
      .out_last  (rsp_tlast),
      .free      (emit_free)
   );

   assign rsp_tdata = RSP_DATA_BITS'(rsp_item);
   assign rsp_tuser = rsp_kind;

   `TLSCP_ASSERT_NOW(a_close_needs_room, clock, reset, req_tvalid && req_tready && req_tlast, !rsp_tvalid || (rsp_tready && rsp_tlast))
   `TLSCP_ASSERT_NEXT(a_status_leads, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid && rsp_tuser == KIND_STATUS)
   `TLSCP_ASSERT_NOW(a_fail_no_text, clock, reset, rsp_tvalid && rsp_tuser == KIND_STATUS && rsp_item.status != ST_OK, rsp_item.sni_length == 5'd0 && rsp_item.alpn_length == 5'd0 && rsp_tlast)

endmodule

`default_nettype wire
